// ----- rtl/grid_biquadratic_interpolator_assert.svh -----
// Assertion macros for the grid interpolator.
// Used by every RTL file that checks its own logic; expects clock and reset in scope.
`ifndef GRID_BIQUADRATIC_INTERPOLATOR_ASSERT_SVH
`define GRID_BIQUADRATIC_INTERPOLATOR_ASSERT_SVH

// cons must hold in the same cycle as ante
`define GBI_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("grid interpolator: same-cycle check failed");

// cons must hold in the cycle after ante
`define GBI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("grid interpolator: next-cycle check failed");

`endif

// ----- rtl/gbi_pkg.sv -----
// Shared types and constants of the grid interpolator.
// No dependencies; used by gbi_mul, grid_biquadratic_interpolator and tb_top.
package gbi_pkg;

   localparam int GRID_WORDS = 65536;   // power of two
   localparam int FRAC_BITS  = 16;
   localparam int ADDR_W     = $clog2(GRID_WORDS);
   localparam int DIM_W      = 13;
   localparam int POS_W      = 32;
   localparam int OUT_W      = 32;
   localparam int IDX_W      = 16;
   localparam int VAL_W      = 64;
   localparam int OFF_W      = POS_W + 2;
   localparam int CSR_IDX_W  = 1;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

   localparam logic signed [VAL_W-1:0] SAT_POS = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] SAT_NEG = {1'b1, {(VAL_W-2){1'b0}}, 1'b1};

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = CSR_IDX_W'(1);

   typedef struct packed {
      logic                    command;
      logic [IDX_W-1:0]        word_index;
      logic signed [OUT_W-1:0] word_value;
      logic [POS_W-1:0]        x_pos;
      logic [POS_W-1:0]        y_pos;
      logic                    last_query;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] height_out;
      logic                    last_result;
      logic                    overflow;
   } rsp_type;

   typedef struct packed {
      logic go;
      logic half;    // round to FRAC_BITS + 1 instead of FRAC_BITS
   } mul_cmd_type;

   typedef struct packed {
      logic                    done;
      logic                    sat;
      logic signed [VAL_W-1:0] value;
   } mul_rsp_type;

endpackage

// ----- rtl/gbi_mul.sv -----
// Sequential signed multiply, round half away from zero, shift and saturate.
// One 32x32 multiplier, four partial products per operation; uses gbi_pkg.
`include "grid_biquadratic_interpolator_assert.svh"

module gbi_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  gbi_pkg::mul_cmd_type            mul_cmd,
   input  logic signed [gbi_pkg::VAL_W-1:0] op_a,
   input  logic signed [gbi_pkg::VAL_W-1:0] op_b,
   output gbi_pkg::mul_rsp_type            mul_rsp
);
   import gbi_pkg::*;

   localparam int HALF_W = VAL_W / 2;
   localparam int PROD_W = 2 * VAL_W;

   logic              run_ff, run_in;
   logic [1:0]        step_ff, step_in;
   logic              pp_vld_ff, pp_vld_in;
   logic              pp_last_ff, pp_last_in;
   logic              fin_ff, fin_in;
   logic              rnd_vld_ff, rnd_vld_in;
   logic              done_ff, done_in;

   logic [VAL_W-1:0]  mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic              neg_ff, neg_in, half_ff, half_in;
   logic [VAL_W-1:0]  pp_ff, pp_in;
   logic [1:0]        pp_sh_ff, pp_sh_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [VAL_W-1:0]  q_ff, q_in;
   logic              qsat_ff, qsat_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic              sat_ff, sat_in;

   logic [HALF_W-1:0] a_part, b_part;
   logic [PROD_W-1:0] pp_wide, rnd, q_full;
   logic [VAL_W-1:0]  abs_a, abs_b;

   always_comb begin
      abs_a  = op_a[VAL_W-1] ? -op_a : op_a;
      abs_b  = op_b[VAL_W-1] ? -op_b : op_b;
      a_part = step_ff[0] ? mag_a_ff[VAL_W-1:HALF_W] : mag_a_ff[HALF_W-1:0];
      b_part = step_ff[1] ? mag_b_ff[VAL_W-1:HALF_W] : mag_b_ff[HALF_W-1:0];

      case (pp_sh_ff)
         2'd0: pp_wide = PROD_W'(pp_ff);
         2'd1: pp_wide = PROD_W'(pp_ff) << HALF_W;
         2'd2: pp_wide = PROD_W'(pp_ff) << VAL_W;
         default: pp_wide = '0;
      endcase

      rnd    = acc_ff + (half_ff ? (PROD_W'(1) << FRAC_BITS) : (PROD_W'(1) << (FRAC_BITS - 1)));
      q_full = half_ff ? (rnd >> (FRAC_BITS + 1)) : (rnd >> FRAC_BITS);

      run_in     = run_ff;
      step_in    = step_ff;
      mag_a_in   = mag_a_ff;
      mag_b_in   = mag_b_ff;
      neg_in     = neg_ff;
      half_in    = half_ff;
      acc_in     = acc_ff;
      pp_in      = VAL_W'(a_part) * VAL_W'(b_part);
      pp_sh_in   = {1'b0, step_ff[0]} + {1'b0, step_ff[1]};
      pp_vld_in  = run_ff;
      pp_last_in = run_ff && (step_ff == 2'd3);
      fin_in     = pp_last_ff;
      rnd_vld_in = fin_ff;
      q_in       = q_full[VAL_W-1:0];
      qsat_in    = |q_full[PROD_W-1:VAL_W-1];
      done_in    = rnd_vld_ff;
      sat_in     = qsat_ff;
      if (qsat_ff) begin
         value_in = neg_ff ? SAT_NEG : SAT_POS;
      end else begin
         value_in = neg_ff ? -$signed(q_ff) : $signed(q_ff);
      end

      if (mul_cmd.go) begin
         mag_a_in = abs_a;
         mag_b_in = abs_b;
         neg_in   = op_a[VAL_W-1] ^ op_b[VAL_W-1];
         half_in  = mul_cmd.half;
         step_in  = 2'd0;
         run_in   = 1'b1;
         acc_in   = '0;
      end else begin
         if (run_ff) begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               run_in = 1'b0;
            end
         end
         if (pp_vld_ff) begin
            acc_in = acc_ff + pp_wide;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         step_ff    <= 2'd0;
         pp_vld_ff  <= 1'b0;
         pp_last_ff <= 1'b0;
         fin_ff     <= 1'b0;
         rnd_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         run_ff     <= run_in;
         step_ff    <= step_in;
         pp_vld_ff  <= pp_vld_in;
         pp_last_ff <= pp_last_in;
         fin_ff     <= fin_in;
         rnd_vld_ff <= rnd_vld_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      neg_ff   <= neg_in;
      half_ff  <= half_in;
      pp_ff    <= pp_in;
      pp_sh_ff <= pp_sh_in;
      acc_ff   <= acc_in;
      q_ff     <= q_in;
      qsat_ff  <= qsat_in;
      value_ff <= value_in;
      sat_ff   <= sat_in;
   end

   assign mul_rsp = '{done: done_ff, sat: sat_ff, value: value_ff};

   // a new operation must never land on one still in flight
   `GBI_ASSERT_SAME(a_go_when_idle, mul_cmd.go, !run_ff && !pp_vld_ff && !fin_ff && !rnd_vld_ff)

endmodule

// ----- rtl/grid_biquadratic_interpolator.sv -----
// Top level of the 3x3 biquadratic grid interpolator.
// Uses gbi_pkg, gbi_mul and the assertion macro header.
`include "grid_biquadratic_interpolator_assert.svh"

// A write item (command 0) stores one Q16.16 grid word and is done in the cycle it is
// taken. A query item (command 1) reads nine grid words from the single-port grid
// memory, three per row, fits a quadratic along each row and one across the rows, and
// raises rsp_strobe for exactly one cycle with the rounded, saturated result; the
// receiver cannot hold it off. busy is high from the query's transfer until the result
// strobe, so queries run one at a time: ten 64-bit products go through one shared
// 32x32 multiplier, four partial products each, around the three-read row loads and
// the saturating adds. Grid words must be written before any query reads them; the
// memory has no reset.
module grid_biquadratic_interpolator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  gbi_pkg::req_type                 req_data,
   output logic                             rsp_strobe,
   output gbi_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [gbi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gbi_pkg::DIM_W-1:0]        csr_wdata
);
   import gbi_pkg::*;

   localparam int BASE_W = 2 * DIM_W + 1;
   localparam logic signed [OFF_W-1:0]   ONE_OFF  = OFF_W'(1) << FRAC_BITS;
   localparam logic signed [VAL_W+1:0]   SAT_WIDE = {2'b00, SAT_POS};
   localparam logic signed [VAL_W-1:0]   OUT_MAX  = {{(VAL_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0]   OUT_MIN  = {{(VAL_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

   typedef enum logic [13:0] {
      S_IDLE = 14'h0001,
      S_BASE = 14'h0002,
      S_HX   = 14'h0004,
      S_HY   = 14'h0008,
      S_RD   = 14'h0010,
      S_D1   = 14'h0020,
      S_D2A  = 14'h0040,
      S_D2B  = 14'h0080,
      S_D2C  = 14'h0100,
      S_M1   = 14'h0200,
      S_M2   = 14'h0400,
      S_S2   = 14'h0800,
      S_OUT  = 14'h1000,
      S_SPARE = 14'h2000
   } state_type;

   typedef struct packed {
      logic [DIM_W-1:0]        corner;
      logic signed [OFF_W-1:0] off;
   } axis_type;

   typedef struct packed {
      logic                    sat;
      logic signed [VAL_W-1:0] value;
   } sum_type;

   // corner of the 3x3 window and the offset into it for one axis
   function automatic axis_type axis_corner(input logic [POS_W-1:0] pos,
                                            input logic [DIM_W-1:0] size);
      logic signed [OFF_W-1:0]   c;
      logic [OFF_W-FRAC_BITS-1:0] k0;
      logic signed [DIM_W:0]     lim;
      logic [DIM_W-1:0]          k;
      axis_type                  r;
      c   = $signed({2'b00, pos}) - ONE_OFF;
      k0  = c[OFF_W-1] ? '0 : c[OFF_W-1:FRAC_BITS];
      lim = $signed({1'b0, size}) - $signed((DIM_W+1)'(3));
      if (lim[DIM_W]) begin
         k = '0;
      end else if (k0 > (OFF_W-FRAC_BITS)'(lim[DIM_W-1:0])) begin
         k = lim[DIM_W-1:0];
      end else begin
         k = k0[DIM_W-1:0];
      end
      r.corner = k;
      r.off    = c - $signed(OFF_W'({k, {FRAC_BITS{1'b0}}}));
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] ext_off(input logic signed [OFF_W-1:0] v);
      return $signed({{(VAL_W-OFF_W){v[OFF_W-1]}}, v});
   endfunction

   // add or subtract, clamped to +-(2^63 - 1)
   function automatic sum_type sat_add(input logic signed [VAL_W-1:0] a,
                                       input logic signed [VAL_W-1:0] b,
                                       input logic sub);
      logic signed [VAL_W+1:0] ax, bx, s;
      sum_type r;
      ax = $signed({{2{a[VAL_W-1]}}, a});
      bx = $signed({{2{b[VAL_W-1]}}, b});
      s  = sub ? (ax - bx) : (ax + bx);
      if (s > SAT_WIDE) begin
         r.sat   = 1'b1;
         r.value = SAT_POS;
      end else if (s < -SAT_WIDE) begin
         r.sat   = 1'b1;
         r.value = SAT_NEG;
      end else begin
         r.sat   = 1'b0;
         r.value = s[VAL_W-1:0];
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   logic [DIM_W-1:0] grid_width_ff, grid_width_in, grid_height_ff, grid_height_in;
   logic             sat_seen_ff, sat_seen_in;
   logic             pend_ff, pend_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]       rd_cnt_ff, rd_cnt_in;
   logic [1:0]       row_ff, row_in;
   logic             col_ff, col_in;

   rsp_type                 rsp_data_ff, rsp_data_in;
   logic                    last_ff, last_in;
   logic [DIM_W-1:0]        cx_ff, cx_in, cy_ff, cy_in;
   logic signed [OFF_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [ADDR_W-1:0]       row_addr_ff, row_addr_in;
   logic signed [VAL_W-1:0] fa_ff, fa_in, fb_ff, fb_in, fc_ff, fc_in;
   logic signed [VAL_W-1:0] d1_ff, d1_in, d2_ff, d2_in, t_ff, t_in, m1_ff, m1_in;
   logic signed [VAL_W-1:0] hx_ff, hx_in, hy_ff, hy_in;
   logic signed [VAL_W-1:0] row_a_ff, row_a_in, row_b_ff, row_b_in;

   logic signed [OUT_W-1:0] mem [GRID_WORDS];
   logic signed [OUT_W-1:0] mem_q_ff;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_addr;

   logic                    accept;
   axis_type                ax_x, ax_y;
   logic signed [VAL_W-1:0] add_a, add_b, sample;
   logic                    add_sub;
   sum_type                 sum;
   mul_cmd_type             mul_cmd;
   mul_rsp_type             mul_rsp;
   logic signed [VAL_W-1:0] mul_a, mul_b;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign mem_we = accept && (req_data.command == CMD_WRITE)
                   && (32'(req_data.word_index) < GRID_WORDS);
   assign mem_addr = mem_we ? ADDR_W'(req_data.word_index)
                            : (row_addr_ff + ADDR_W'(rd_cnt_ff));
   assign sample = $signed({{(VAL_W-OUT_W){mem_q_ff[OUT_W-1]}}, mem_q_ff});
   assign ax_x   = axis_corner(req_data.x_pos, grid_width_ff);
   assign ax_y   = axis_corner(req_data.y_pos, grid_height_ff);
   assign sum    = sat_add(add_a, add_b, add_sub);

   gbi_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_cmd (mul_cmd),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .mul_rsp (mul_rsp)
   );

   always_comb begin
      state_in       = state_ff;
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      sat_seen_in    = sat_seen_ff;
      pend_in        = pend_ff;
      rsp_strobe_in  = 1'b0;
      rd_cnt_in      = rd_cnt_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      rsp_data_in    = rsp_data_ff;
      last_in        = last_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      row_addr_in    = row_addr_ff;
      fa_in          = fa_ff;
      fb_in          = fb_ff;
      fc_in          = fc_ff;
      d1_in          = d1_ff;
      d2_in          = d2_ff;
      t_in           = t_ff;
      m1_in          = m1_ff;
      hx_in          = hx_ff;
      hy_in          = hy_ff;
      row_a_in       = row_a_ff;
      row_b_in       = row_b_ff;
      add_a          = fb_ff;
      add_b          = fa_ff;
      add_sub        = 1'b1;
      mul_a          = col_ff ? ext_off(py_ff) : ext_off(px_ff);
      mul_b          = d1_ff;
      mul_cmd        = '{go: 1'b0, half: 1'b0};

      if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = csr_wdata;
            CSR_GRID_HEIGHT: grid_height_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_data.command == CMD_QUERY)) begin
               cx_in       = ax_x.corner;
               px_in       = ax_x.off;
               cy_in       = ax_y.corner;
               py_in       = ax_y.off;
               last_in     = req_data.last_query;
               sat_seen_in = 1'b0;
               state_in    = S_BASE;
            end
         end
         S_BASE: begin
            row_addr_in = ADDR_W'(BASE_W'(cx_ff) + BASE_W'(cy_ff) * BASE_W'(grid_width_ff));
            row_in      = 2'd0;
            col_in      = 1'b0;
            rd_cnt_in   = 2'd0;
            state_in    = S_HX;
         end
         S_HX, S_HY: begin
            mul_a       = (state_ff == S_HX) ? ext_off(px_ff) : ext_off(py_ff);
            mul_b       = (state_ff == S_HX) ? ext_off(px_ff - ONE_OFF)
                                             : ext_off(py_ff - ONE_OFF);
            mul_cmd.half = 1'b1;
            mul_cmd.go   = !pend_ff;
            if (!pend_ff) begin
               pend_in = 1'b1;
            end
            if (mul_rsp.done) begin
               pend_in     = 1'b0;
               sat_seen_in = sat_seen_ff | mul_rsp.sat;
               if (state_ff == S_HX) begin
                  hx_in    = mul_rsp.value;
                  state_in = S_HY;
               end else begin
                  hy_in    = mul_rsp.value;
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            // read data is registered, so it arrives the cycle after its address: shift in once rd_cnt_ff is past zero
            rd_cnt_in = rd_cnt_ff + 2'd1;
            if (rd_cnt_ff != 2'd0) begin
               fa_in = fb_ff;
               fb_in = fc_ff;
               fc_in = sample;
            end
            if (rd_cnt_ff == 2'd3) begin
               state_in = S_D1;
            end
         end
         S_D1: begin
            d1_in       = sum.value;
            sat_seen_in = sat_seen_ff | sum.sat;
            state_in    = S_D2A;
         end
         S_D2A: begin
            add_a       = fc_ff;
            add_b       = fa_ff;
            add_sub     = 1'b0;
            t_in        = sum.value;
            sat_seen_in = sat_seen_ff | sum.sat;
            state_in    = S_D2B;
         end
         S_D2B: begin
            add_a       = t_ff;
            add_b       = fb_ff;
            t_in        = sum.value;
            sat_seen_in = sat_seen_ff | sum.sat;
            state_in    = S_D2C;
         end
         S_D2C: begin
            add_a       = t_ff;
            add_b       = fb_ff;
            d2_in       = sum.value;
            sat_seen_in = sat_seen_ff | sum.sat;
            state_in    = S_M1;
         end
         S_M1: begin
            mul_cmd.go = !pend_ff;
            if (!pend_ff) begin
               pend_in = 1'b1;
            end
            if (mul_rsp.done) begin
               pend_in     = 1'b0;
               m1_in       = mul_rsp.value;
               sat_seen_in = sat_seen_ff | mul_rsp.sat;
               state_in    = S_M2;
            end
         end
         S_M2: begin
            mul_a      = col_ff ? hy_ff : hx_ff;
            mul_b      = d2_ff;
            mul_cmd.go = !pend_ff;
            add_a      = m1_ff;
            add_b      = mul_rsp.value;
            add_sub    = 1'b0;
            if (!pend_ff) begin
               pend_in = 1'b1;
            end
            if (mul_rsp.done) begin
               pend_in     = 1'b0;
               t_in        = sum.value;
               sat_seen_in = sat_seen_ff | mul_rsp.sat | sum.sat;
               state_in    = S_S2;
            end
         end
         S_S2: begin
            add_a       = fa_ff;
            add_b       = t_ff;
            add_sub     = 1'b0;
            sat_seen_in = sat_seen_ff | sum.sat;
            if (col_ff) begin
               t_in     = sum.value;
               state_in = S_OUT;
            end else if (row_ff == 2'd2) begin
               // all three rows done: fit across them
               fa_in    = row_a_ff;
               fb_in    = row_b_ff;
               fc_in    = sum.value;
               col_in   = 1'b1;
               state_in = S_D1;
            end else begin
               row_a_in    = row_b_ff;
               row_b_in    = sum.value;
               row_in      = row_ff + 2'd1;
               row_addr_in = row_addr_ff + ADDR_W'(grid_width_ff);
               rd_cnt_in   = 2'd0;
               state_in    = S_RD;
            end
         end
         S_OUT: begin
            rsp_data_in.last_result = last_ff;
            rsp_data_in.overflow    = 1'b1;
            if (sat_seen_ff) begin
               rsp_data_in.height_out = t_ff[VAL_W-1] ? OUT_MIN[OUT_W-1:0] : OUT_MAX[OUT_W-1:0];
            end else if (t_ff > OUT_MAX) begin
               rsp_data_in.height_out = OUT_MAX[OUT_W-1:0];
            end else if (t_ff < OUT_MIN) begin
               rsp_data_in.height_out = OUT_MIN[OUT_W-1:0];
            end else begin
               rsp_data_in.height_out = t_ff[OUT_W-1:0];
               rsp_data_in.overflow   = 1'b0;
            end
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         grid_width_ff  <= DIM_RESET;
         grid_height_ff <= DIM_RESET;
         sat_seen_ff    <= 1'b0;
         pend_ff        <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         rd_cnt_ff      <= 2'd0;
         row_ff         <= 2'd0;
         col_ff         <= 1'b0;
      end else begin
         state_ff       <= state_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         sat_seen_ff    <= sat_seen_in;
         pend_ff        <= pend_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         rd_cnt_ff      <= rd_cnt_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      last_ff     <= last_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      row_addr_ff <= row_addr_in;
      fa_ff       <= fa_in;
      fb_ff       <= fb_in;
      fc_ff       <= fc_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      t_ff        <= t_in;
      m1_ff       <= m1_in;
      hx_ff       <= hx_in;
      hy_ff       <= hy_in;
      row_a_ff    <= row_a_in;
      row_b_ff    <= row_b_in;
   end

   // grid memory: one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= req_data.word_value;
      end
      mem_q_ff <= mem[mem_addr];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `GBI_ASSERT_NEXT(a_query_goes_busy, accept && (req_data.command == CMD_QUERY), busy)
   `GBI_ASSERT_SAME(a_strobe_after_out, rsp_strobe_ff, $past(state_ff == S_OUT) && !busy)
   `GBI_ASSERT_SAME(a_mul_done_expected, mul_rsp.done, pend_ff && (state_ff == S_HX || state_ff == S_HY || state_ff == S_M1 || state_ff == S_M2))

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for grid_biquadratic_interpolator: grid loads and
// 3x3 biquadratic queries checked against an in-bench fixed-point predictor.
// Depends on gbi_pkg and the interpolator RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int          QUERY_LATENCY = 130;   // wait that lets a query finish, plus margin
   localparam int          STALL_LIMIT   = 2000;
   localparam int unsigned PHASE_ITEMS   = 100;
   localparam longint      UNIT          = longint'(1) << gbi_pkg::FRAC_BITS;
   localparam longint      OUT_MAX       = 64'sd2147483647;
   localparam longint      OUT_MIN       = -64'sd2147483648;
   localparam logic signed [64:0] SUM_HI = 65'sd9223372036854775807;
   localparam logic signed [64:0] SUM_LO = -65'sd9223372036854775807;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   gbi_pkg::req_type                     req_data;
   logic                                 rsp_strobe;
   gbi_pkg::rsp_type                     rsp_data;
   logic                                 csr_we;
   logic [gbi_pkg::CSR_IDX_W-1:0]        csr_index;
   logic [gbi_pkg::DIM_W-1:0]            csr_wdata;

   // grid contents and sizes as the block should hold them
   logic [31:0]                          grid_model [gbi_pkg::GRID_WORDS];
   bit                                   grid_written [gbi_pkg::GRID_WORDS];
   logic [gbi_pkg::DIM_W-1:0]            cols = gbi_pkg::DIM_RESET;
   logic [gbi_pkg::DIM_W-1:0]            rows = gbi_pkg::DIM_RESET;
   bit                                   sat_hit;

   gbi_pkg::rsp_type                     expected_heights [$];
   bit                                   sender_idles = 1'b1;
   int unsigned                          items_sent;
   int unsigned                          heights_checked;
   int unsigned                          heights_saturated;
   int unsigned                          size_settings;
   int unsigned                          mismatch_count;
   int                                   stall_cycles;

   grid_biquadratic_interpolator i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // saturating 64-bit add, clamped to +-(2^63 - 1)
   function automatic longint clip_sum(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > SUM_HI) begin
         sat_hit = 1'b1;
         return gbi_pkg::SAT_POS;
      end
      if (s < SUM_LO) begin
         sat_hit = 1'b1;
         return gbi_pkg::SAT_NEG;
      end
      return s[63:0];
   endfunction

   // a * b / 2^sh, rounded half away from zero, saturated
   function automatic longint mul_round(longint a, longint b, int unsigned sh);
      logic [63:0]  ua, ub;
      logic [127:0] prod;
      logic         neg;
      neg  = (a < 0) != (b < 0);
      ua   = (a < 0) ? -a : a;
      ub   = (b < 0) ? -b : b;
      prod = {64'd0, ua} * {64'd0, ub};
      prod = (prod + (128'd1 << (sh - 1))) >> sh;
      if (prod > {64'd0, gbi_pkg::SAT_POS}) begin
         sat_hit = 1'b1;
         return neg ? gbi_pkg::SAT_NEG : gbi_pkg::SAT_POS;
      end
      return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
   endfunction

   function automatic longint fit_quadratic(longint p, longint h,
                                            longint f0, longint f1, longint f2);
      longint d1, d2;
      d1 = clip_sum(f1, -f0);
      d2 = clip_sum(clip_sum(clip_sum(f2, f0), -f1), -f1);
      return clip_sum(f0, clip_sum(mul_round(p, d1, gbi_pkg::FRAC_BITS),
                                   mul_round(h, d2, gbi_pkg::FRAC_BITS)));
   endfunction

   // window corner on one axis; off gets the 0-based offset from that corner
   function automatic longint axis_corner(logic [31:0] pos, logic [gbi_pkg::DIM_W-1:0] size,
                                          output longint off);
      longint c, k, lim;
      c   = $signed({32'd0, pos}) - UNIT;
      k   = (c < 0) ? 0 : (c >>> gbi_pkg::FRAC_BITS);
      lim = $signed({51'd0, size}) - 3;
      if (k > lim) k = lim;
      if (k < 0) k = 0;
      off = c - k * UNIT;
      return k;
   endfunction

   function automatic longint grid_sample(logic [63:0] addr);
      return longint'($signed(grid_model[addr[gbi_pkg::ADDR_W-1:0]]));
   endfunction

   function automatic gbi_pkg::rsp_type predict_height(gbi_pkg::req_type q);
      longint           px, py, hx, hy, cx, cy, v;
      longint           fits [3];
      logic [63:0]      base, a;
      gbi_pkg::rsp_type r;
      int               i;
      sat_hit = 1'b0;
      cx   = axis_corner(q.x_pos, cols, px);
      cy   = axis_corner(q.y_pos, rows, py);
      hx   = mul_round(px, px - UNIT, gbi_pkg::FRAC_BITS + 1);
      hy   = mul_round(py, py - UNIT, gbi_pkg::FRAC_BITS + 1);
      base = 64'(cx) + 64'(cy) * 64'(cols);
      for (i = 0; i < 3; i++) begin
         a       = base + 64'(i) * 64'(cols);
         fits[i] = fit_quadratic(px, hx, grid_sample(a), grid_sample(a + 1),
                                 grid_sample(a + 2));
      end
      v = fit_quadratic(py, hy, fits[0], fits[1], fits[2]);
      r.last_result = q.last_query;
      r.overflow    = 1'b1;
      if (sat_hit)
         r.height_out = (v >= 0) ? OUT_MAX[31:0] : OUT_MIN[31:0];
      else if (v > OUT_MAX)
         r.height_out = OUT_MAX[31:0];
      else if (v < OUT_MIN)
         r.height_out = OUT_MIN[31:0];
      else begin
         r.height_out = v[31:0];
         r.overflow   = 1'b0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic gbi_pkg::req_type make_write(logic [gbi_pkg::IDX_W-1:0] idx,
                                                   logic [31:0] val);
      gbi_pkg::req_type item;
      item.command    = gbi_pkg::CMD_WRITE;
      item.word_index = idx;
      item.word_value = val;
      item.x_pos      = $urandom();
      item.y_pos      = $urandom();
      item.last_query = 1'($urandom_range(1));
      return item;
   endfunction

   function automatic gbi_pkg::req_type make_query(logic [31:0] x, logic [31:0] y,
                                                   logic last);
      gbi_pkg::req_type item;
      item.command    = gbi_pkg::CMD_QUERY;
      item.word_index = gbi_pkg::IDX_W'($urandom());
      item.word_value = $urandom();
      item.x_pos      = x;
      item.y_pos      = y;
      item.last_query = last;
      return item;
   endfunction

   function automatic logic [31:0] random_sample();
      if ($urandom_range(99) < 80)
         return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
      return $urandom();
   endfunction

   // mostly inside the grid, some near or past the edges, some anywhere
   function automatic logic [31:0] pick_pos(logic [gbi_pkg::DIM_W-1:0] size);
      int unsigned span, sel;
      span = (size < 3) ? 3 : 32'(size);
      sel  = $urandom_range(99);
      if (sel < 65) return $urandom_range(0, (span + 1) << 16);
      if (sel < 75) return $urandom_range(0, 32'h0002_0000);
      if (sel < 85) return ((span - 1) << 16) + $urandom_range(0, 32'h0003_0000);
      return $urandom();
   endfunction

   task automatic send_item(input gbi_pkg::req_type item);
      int gap;
      gap = 0;
      if (sender_idles && $urandom_range(99) < 30)
         gap = $urandom_range(1, ($urandom_range(3) == 0) ? 130 : 4);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      items_sent++;
      if (item.command == gbi_pkg::CMD_QUERY)
         expected_heights.push_back(predict_height(item));
      else begin
         grid_model[item.word_index]   = item.word_value;
         grid_written[item.word_index] = 1'b1;
      end
   endtask

   // drop start, let every pending height come back, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (expected_heights.size() != 0) @(negedge clock);
      repeat (QUERY_LATENCY) @(negedge clock);
   endtask

   task automatic set_grid_size(input logic [gbi_pkg::DIM_W-1:0] w,
                                input logic [gbi_pkg::DIM_W-1:0] h);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= gbi_pkg::CSR_GRID_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= gbi_pkg::CSR_GRID_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_we <= 1'b0;
      cols = w;
      rows = h;
      size_settings++;
   endtask

   // load any word of the 3x3 window that was never written, then ask
   task automatic query_point(input logic [31:0] x, input logic [31:0] y, input logic last);
      longint      cx, cy, ox, oy;
      logic [63:0] addr;
      int          r, c;
      cx = axis_corner(x, cols, ox);
      cy = axis_corner(y, rows, oy);
      for (r = 0; r < 3; r++)
         for (c = 0; c < 3; c++) begin
            addr = 64'(cx) + (64'(cy) + 64'(r)) * 64'(cols) + 64'(c);
            if (!grid_written[addr[gbi_pkg::ADDR_W-1:0]])
               send_item(make_write(addr[gbi_pkg::ADDR_W-1:0], random_sample()));
         end
      send_item(make_query(x, y, last));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_plain_fit();
      logic [31:0] fill [9];
      int          i;
      fill = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF,
               32'h1234_5678, 32'hFFFF_8000, 32'h0003_0000};
      set_grid_size(gbi_pkg::DIM_W'(3), gbi_pkg::DIM_W'(3));
      for (i = 0; i < 9; i++)
         send_item(make_write(gbi_pkg::IDX_W'(i), fill[i]));
      query_point(32'h0002_0000, 32'h0002_0000, 1'b0);
      query_point(32'h0001_0000, 32'h0001_0000, 1'b0);
      query_point(32'h0003_0000, 32'h0003_0000, 1'b0);
      query_point(32'h0001_8000, 32'h0002_4000, 1'b1);
   endtask

   // coordinates before the first and past the last sample
   task automatic test_extrapolation();
      query_point(32'h0000_0000, 32'h0000_0000, 1'b0);
      query_point(32'h0004_1234, 32'h0002_0000, 1'b1);
      query_point(32'h0000_FFFF, 32'h0003_FFFF, 1'b0);
   endtask

   // far-off coordinates overflow the 64-bit products
   task automatic test_saturation();
      query_point(32'hFFFF_FFFF, 32'h0002_0000, 1'b0);
      query_point(32'h0002_0000, 32'hFFFF_FFFF, 1'b1);
   endtask

   task automatic test_undersized_grid();
      set_grid_size(gbi_pkg::DIM_W'(1), gbi_pkg::DIM_W'(2));
      query_point(32'h0003_0000, 32'h0001_8000, 1'b1);
      set_grid_size(gbi_pkg::DIM_W'(0), gbi_pkg::DIM_W'(0));
      query_point(32'h0002_8000, 32'h0001_0000, 1'b0);
   endtask

   task automatic test_random_traffic();
      int unsigned               phase, phase_start, sel;
      logic [gbi_pkg::DIM_W-1:0] w, h;
      bit                        paused;
      paused = 1'b0;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin w = gbi_pkg::DIM_W'(4096); h = gbi_pkg::DIM_W'(4096); end
            1: begin w = gbi_pkg::DIM_W'(3); h = gbi_pkg::DIM_W'(4096); end
            2: begin w = gbi_pkg::DIM_W'(4096); h = gbi_pkg::DIM_W'(3); end
            4: begin w = gbi_pkg::DIM_W'(8191); h = gbi_pkg::DIM_W'(8191); end
            5: begin
               w = gbi_pkg::DIM_W'($urandom_range(0, 2));
               h = gbi_pkg::DIM_W'($urandom_range(3, 9));
            end
            7: begin w = gbi_pkg::DIM_W'(3); h = gbi_pkg::DIM_W'(3); end
            default: begin
               w = gbi_pkg::DIM_W'($urandom_range(3, 40));
               h = gbi_pkg::DIM_W'($urandom_range(3, 40));
            end
         endcase
         set_grid_size(w, h);
         sender_idles = (phase != 3);
         phase_start  = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 12)
               send_item(make_write(gbi_pkg::IDX_W'($urandom()), random_sample()));
            else
               query_point(pick_pos(w), pick_pos(h), 1'($urandom_range(1)));
            // hold the sender until everything in flight has come back
            if (sel == 99 || (phase == 1 && !paused && items_sent - phase_start > 50)) begin
               paused = 1'b1;
               wait_idle();
            end
         end
      end
      sender_idles = 1'b1;
   endtask

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      gbi_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_heights.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: height %0d with no query pending", $time, rsp_data.height_out);
         end else begin
            want = expected_heights.pop_front();
            heights_checked++;
            if (want.overflow) heights_saturated++;
            if (rsp_data.height_out !== want.height_out ||
                rsp_data.last_result !== want.last_result ||
                rsp_data.overflow !== want.overflow) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: expected height %0d last %0b ovf %0b, got %0d last %0b ovf %0b",
                           $time, want.height_out, want.last_result, want.overflow,
                           rsp_data.height_out, rsp_data.last_result, rsp_data.overflow);
            end
         end
      end
   end

   // abort when neither side moves a transfer for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", stall_cycles);
         $display("[grid_biquadratic_interpolator] ERROR");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_plain_fit();
      test_extrapolation();
      test_saturation();
      test_undersized_grid();
      test_random_traffic();
      wait_idle();

      $display("Sent %0d loads and queries over %0d grid sizes; checked %0d heights",
               items_sent, size_settings, heights_checked);
      $display("%0d heights saturated, %0d mismatches", heights_saturated, mismatch_count);
      if (mismatch_count == 0)
         $display("[grid_biquadratic_interpolator] OK");
      else
         $display("[grid_biquadratic_interpolator] ERROR");
      $finish;
   end

endmodule
